### rtl/core/fft_bandpass_frame_filter_core_defines.svh
// assertion macros for the band-pass frame filter
`ifndef FFT_BANDPASS_FRAME_FILTER_CORE_DEFINES_SVH
`define FFT_BANDPASS_FRAME_FILTER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FBF_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FBF_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define FBF_ASSERT_IMPL(label, clk, rst, prop, msg)
`define FBF_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### rtl/core/fbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fbf_pkg;
  localparam int FRAME_LEN_DEF = 64;
  localparam int DW = 24;
  localparam int SW = 16;
  localparam int TW = 16;

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_STOP  = 2'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_ZFILL, ST_BREV, ST_BFLY, ST_FILT, ST_MIRR, ST_EMIT
  } state_t;

  // controller commands and datapath status
  typedef struct packed {
    logic load;      // write an input sample
    logic zfill;     // write zero at index
    logic brev;      // one bit-reverse swap step
    logic bfly;      // one butterfly step
    logic inverse;
    logic filt;      // band mask step
    logic mirr;      // conjugate mirror step
    logic emit;      // output step
  } cmd_t;

  typedef struct packed {
    logic step_done; // current multi-cycle step finished
  } sts_t;

  // shift-subtract quotient of non-negative values, elaboration-time tables only
  function automatic longint div_floor(input longint a, input longint b);
    longint q, r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r <<< 1) | ((a >>> i) & 64'sd1);
      if (r >= b) begin
        r = r - b;
        q = q | (64'sd1 <<< i);
      end
    end
    return q;
  endfunction

  // sin((pi/2)*num/den) in Q1.15 by Taylor series at elaboration time
  function automatic logic [TW-1:0] sin_q(input longint num, input longint den);
    longint x, term, sum;
    x = div_floor(64'sd1686629713 * num, den);
    term = x;
    sum = x;
    for (int n = 1; n <= 9; n++) begin
      term = (term * x) >>> 30;
      term = div_floor((term * x) >>> 30, longint'((2 * n) * (2 * n + 1)));
      if ((n & 1) == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) sum = 32767;
    return sum[TW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat24(input logic signed [DW+2:0] v);
    if (v > $signed({{3{1'b0}}, 1'b0, {(DW-1){1'b1}}})) return {1'b0, {(DW-1){1'b1}}};
    if (v < $signed({{3{1'b1}}, 1'b1, {(DW-1){1'b0}}})) return {1'b1, {(DW-1){1'b0}}};
    return v[DW-1:0];
  endfunction
endpackage
`default_nettype wire

### rtl/core/fbf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module fbf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_take,
  input  wire logic          frame_end,
  input  wire fbf_pkg::sts_t sts,
  input  wire logic          out_free,
  output fbf_pkg::cmd_t      cmd,
  output logic               in_ready
);
  import fbf_pkg::*;
  state_t state, state_next;
  logic   inv, inv_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      inv   <= 1'b0;
    end else begin
      state <= state_next;
      inv   <= inv_next;
    end
  end

  always_comb begin
    state_next  = state;
    inv_next    = inv;
    cmd         = '0;
    cmd.inverse = inv;
    in_ready    = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_take;
        inv_next = 1'b0;
        if (in_take && frame_end) state_next = ST_ZFILL;
      end
      ST_ZFILL: begin
        cmd.zfill = 1'b1;
        if (sts.step_done) state_next = ST_BREV;
      end
      ST_BREV: begin
        cmd.brev = 1'b1;
        if (sts.step_done) state_next = ST_BFLY;
      end
      ST_BFLY: begin
        cmd.bfly = 1'b1;
        if (sts.step_done) state_next = inv ? ST_EMIT : ST_FILT;
      end
      ST_FILT: begin
        cmd.filt = 1'b1;
        if (sts.step_done) state_next = ST_MIRR;
      end
      ST_MIRR: begin
        cmd.mirr = 1'b1;
        if (sts.step_done) begin
          state_next = ST_BREV;
          inv_next   = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.emit = out_free;
        if (out_free && sts.step_done) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/fbf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module fbf_datapath #(
  parameter int FRAME_LEN = fbf_pkg::FRAME_LEN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fbf_pkg::cmd_t                 cmd,
  input  wire logic signed [fbf_pkg::SW-1:0] sample,
  input  wire logic                          last_in,
  input  wire logic [7:0]                    start_freq,
  input  wire logic [7:0]                    stop_freq,
  output fbf_pkg::sts_t                      sts,
  output logic                               frame_end,
  output logic                               out_load,
  output logic signed [fbf_pkg::SW-1:0]      out_data,
  output logic                               out_last
);
  import fbf_pkg::*;
  localparam int AW = $clog2(FRAME_LEN);
  localparam int Q4 = FRAME_LEN / 4;
  localparam int HALF = FRAME_LEN / 2;
  localparam int SB = (AW > 1) ? $clog2(AW) : 1;

  // twiddle table cos/sin of 2*pi*k/N for k < N/2
  typedef logic signed [TW-1:0] tw_arr_t [HALF];
  function automatic tw_arr_t mk_cos();
    tw_arr_t t;
    for (int k = 0; k < HALF; k++) begin
      if (k < Q4) t[k] = sin_q(Q4 - k, Q4);
      else t[k] = -$signed(sin_q(k - Q4, Q4));
    end
    return t;
  endfunction
  function automatic tw_arr_t mk_sin();
    tw_arr_t t;
    for (int k = 0; k < HALF; k++) begin
      if (k < Q4) t[k] = sin_q(k, Q4);
      else t[k] = sin_q(Q4 - (k - Q4), Q4);
    end
    return t;
  endfunction
  localparam tw_arr_t COS_T = mk_cos();
  localparam tw_arr_t SIN_T = mk_sin();

  logic [2*DW-1:0] mem [FRAME_LEN];
  logic [AW:0]     cnt;          // load count or index sweep
  logic [SB-1:0]   stage;
  logic [AW-2:0]   bidx;         // butterfly number within stage
  logic [2:0]      ph;           // phase within a multi-cycle step
  logic [AW-1:0]   ia, ib;
  logic [2*DW-1:0] ra, rb;
  logic [AW:0]     lo_bin, hi_bin;

  function automatic logic [AW-1:0] rev(input logic [AW-1:0] v);
    for (int b = 0; b < AW; b++) rev[b] = v[AW-1-b];
  endfunction

  function automatic logic [AW:0] to_bin(input logic [7:0] f);
    logic [AW+7:0] p;
    p = ({{AW{1'b0}}, f} << AW) >> 7;
    if (p > (AW+8)'(HALF + 1)) return (AW+1)'(HALF + 1);
    return p[AW:0];
  endfunction

  assign lo_bin = to_bin(start_freq);
  assign hi_bin = to_bin(stop_freq);

  // butterfly addresses
  logic [AW-1:0] hmask, hsz, jj, twk;
  always_comb begin
    hsz   = AW'(1) << stage;
    hmask = hsz - AW'(1);
    jj    = {1'b0, bidx} & hmask;
    ia    = ((({1'b0, bidx} & ~hmask)) << 1) | jj;
    ib    = ia | hsz;
    twk   = jj << (SB'(AW - 1) - stage);
  end

  // registered product stage
  logic signed [DW-1:0]   ar, ai, br, bi;
  logic signed [TW-1:0]   wc, ws;
  logic signed [DW+TW:0]  p1, p2, p3, p4;
  logic signed [DW+1:0]   tr, ti;
  logic signed [DW+2:0]   s0, s1, s2, s3;
  logic signed [DW-1:0]   o0, o1, o2, o3;
  always_comb begin
    ar = ra[2*DW-1:DW]; ai = ra[DW-1:0];
    br = rb[2*DW-1:DW]; bi = rb[DW-1:0];
    wc = COS_T[twk[AW-2:0]];
    ws = cmd.inverse ? SIN_T[twk[AW-2:0]] : -SIN_T[twk[AW-2:0]];
  end
  logic signed [DW+TW+1:0] sr, si;
  always_comb begin
    sr = (DW+TW+2)'(p1) - (DW+TW+2)'(p2) + (DW+TW+2)'(16384);
    si = (DW+TW+2)'(p3) + (DW+TW+2)'(p4) + (DW+TW+2)'(16384);
    tr = (DW+2)'(sr >>> 15);
    ti = (DW+2)'(si >>> 15);
    s0 = (DW+3)'(ar) + (DW+3)'(tr);
    s1 = (DW+3)'(ai) + (DW+3)'(ti);
    s2 = (DW+3)'(ar) - (DW+3)'(tr);
    s3 = (DW+3)'(ai) - (DW+3)'(ti);
    if (cmd.inverse) begin
      o0 = sat24(s0); o1 = sat24(s1); o2 = sat24(s2); o3 = sat24(s3);
    end else begin
      o0 = sat24((s0 + (DW+3)'(1)) >>> 1); o1 = sat24((s1 + (DW+3)'(1)) >>> 1);
      o2 = sat24((s2 + (DW+3)'(1)) >>> 1); o3 = sat24((s3 + (DW+3)'(1)) >>> 1);
    end
  end

  logic [AW-1:0] ci;
  logic [AW-1:0] mi;
  logic signed [DW-1:0] mre, mim, ore;
  logic signed [DW-8:0] rnd;
  assign ci  = cnt[AW-1:0];
  assign mi  = AW'(FRAME_LEN) - ci;
  assign mre = ra[2*DW-1:DW];
  assign mim = ra[DW-1:0];
  assign ore = ra[2*DW-1:DW];
  // one guard bit so the rounding offset cannot wrap
  assign rnd = (DW-7)'(((DW+1)'(ore) + (DW+1)'(128)) >>> 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; stage <= '0; bidx <= '0; ph <= '0; out_load <= 1'b0;
    end else begin
      out_load <= 1'b0;
      if (cmd.load) begin
        mem[ci] <= {DW'(sample) <<< 8, DW'(0)};
        cnt <= cnt + 1'b1;
      end else if (cmd.zfill) begin
        if (cnt[AW]) cnt <= '0;
        else begin
          mem[ci] <= '0;
          cnt <= cnt + 1'b1;
        end
      end else if (cmd.brev) begin
        unique case (ph)
          3'd0: begin ra <= mem[ci]; ph <= 3'd1; end
          3'd1: begin rb <= mem[rev(ci)]; ph <= 3'd2; end
          3'd2: begin
            if (rev(ci) > ci) begin
              mem[ci] <= rb;
              mem[rev(ci)] <= ra;
            end
            ph <= 3'd0;
            cnt <= (ci == AW'(FRAME_LEN - 1)) ? '0 : cnt + 1'b1;
          end
          default: ph <= 3'd0;
        endcase
      end else if (cmd.bfly) begin
        unique case (ph)
          3'd0: begin ra <= mem[ia]; ph <= 3'd1; end
          3'd1: begin rb <= mem[ib]; ph <= 3'd2; end
          3'd2: begin
            p1 <= br * wc; p2 <= bi * ws; p3 <= br * ws; p4 <= bi * wc;
            ph <= 3'd3;
          end
          3'd3: begin mem[ia] <= {o0, o1}; ph <= 3'd4; end
          3'd4: begin
            mem[ib] <= {o2, o3};
            ph <= 3'd0;
            if (&bidx) begin
              bidx <= '0;
              stage <= (stage == SB'(AW - 1)) ? '0 : stage + 1'b1;
            end else bidx <= bidx + 1'b1;
          end
          default: ph <= 3'd0;
        endcase
      end else if (cmd.filt) begin
        unique case (ph)
          3'd0: begin ra <= mem[ci]; ph <= 3'd1; end
          3'd1: begin
            if ({1'b0, ci} < lo_bin || {1'b0, ci} >= hi_bin) mem[ci] <= '0;
            else if (ci == '0 || ci == AW'(HALF))
              mem[ci] <= {ra[2*DW-1:DW], DW'(0)};
            ph <= 3'd0;
            cnt <= (ci == AW'(HALF)) ? (AW+1)'(HALF + 1) : cnt + 1'b1;
          end
          default: ph <= 3'd0;
        endcase
      end else if (cmd.mirr) begin
        unique case (ph)
          3'd0: begin ra <= mem[mi]; ph <= 3'd1; end
          3'd1: begin
            mem[ci] <= {mre, sat24(-(DW+3)'(mim))};
            ph <= 3'd0;
            cnt <= (ci == AW'(FRAME_LEN - 1)) ? '0 : cnt + 1'b1;
          end
          default: ph <= 3'd0;
        endcase
      end else if (cmd.emit) begin
        unique case (ph)
          3'd0: begin ra <= mem[ci]; ph <= 3'd1; end
          3'd1: begin
            if (rnd > (DW-7)'(32767)) out_data <= 16'sh7fff;
            else if (rnd < -(DW-7)'(32768)) out_data <= -16'sh8000;
            else out_data <= rnd[SW-1:0];
            out_last <= (ci == AW'(FRAME_LEN - 1));
            out_load <= 1'b1;
            ph <= 3'd0;
            cnt <= (ci == AW'(FRAME_LEN - 1)) ? '0 : cnt + 1'b1;
          end
          default: ph <= 3'd0;
        endcase
      end
    end
  end

  assign frame_end = last_in || (ci == AW'(FRAME_LEN - 1));

  always_comb begin
    sts.step_done = 1'b0;
    if (cmd.zfill) sts.step_done = cnt[AW];
    else if (cmd.brev) sts.step_done = (ph == 3'd2) && (ci == AW'(FRAME_LEN - 1));
    else if (cmd.bfly)
      sts.step_done = (ph == 3'd4) && (&bidx) && (stage == SB'(AW - 1));
    else if (cmd.filt) sts.step_done = (ph == 3'd1) && (ci == AW'(HALF));
    else if (cmd.mirr) sts.step_done = (ph == 3'd1) && (ci == AW'(FRAME_LEN - 1));
    else if (cmd.emit) sts.step_done = (ph == 3'd1) && (ci == AW'(FRAME_LEN - 1));
  end
endmodule
`default_nettype wire

### rtl/core/fft_bandpass_frame_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake             | payload
// in       | in_valid / in_stall   | sample, last_in
// out      | out_valid / out_stall | filtered_sample, last_out
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one input sample is accepted per cycle while a frame loads
// after the frame: zero fill of the missing samples, two bit-reverse passes, two
// fft passes of (N/2)*log2(N) butterflies on one shared butterfly unit, band
// mask and mirror passes over the bins, then N outputs
// synchronous active-high reset; the frame memory needs no clearing
// out_stall holds the output register and pauses the emit pass
`include "fft_bandpass_frame_filter_core_defines.svh"
module fft_bandpass_frame_filter_core #(
  parameter int FRAME_LEN = fbf_pkg::FRAME_LEN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [fbf_pkg::SW-1:0] sample,
  input  wire logic                          last_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [fbf_pkg::SW-1:0]      filtered_sample,
  output logic                               last_out,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [7:0]                    cfg_data
);
  import fbf_pkg::*;

  logic [7:0] start_freq, stop_freq;
  cmd_t cmd;
  sts_t sts;
  logic in_ready, in_take, frame_end, out_load, out_free, dp_last;
  logic signed [SW-1:0] dp_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      start_freq <= 8'd0;
      stop_freq  <= 8'd64;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_START) start_freq <= cfg_data;
      else if (cfg_index == CFG_STOP) stop_freq <= cfg_data;
    end
  end

  assign in_stall = !in_ready;
  assign in_take  = in_valid && in_ready;
  // output register is free when empty or being taken
  assign out_free = !out_valid || !out_stall;

  fbf_ctrl u_ctrl (
    .clk, .rst, .in_take, .frame_end, .sts, .out_free, .cmd, .in_ready
  );

  fbf_datapath #(.FRAME_LEN(FRAME_LEN)) u_dp (
    .clk, .rst, .cmd, .sample, .last_in, .start_freq, .stop_freq, .sts,
    .frame_end, .out_load, .out_data(dp_data), .out_last(dp_last)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
  assign filtered_sample = dp_data;
  assign last_out = dp_last;

  `FBF_ASSERT_IMPL(a_take_in_load, clk, rst, in_take |-> cmd.load, "input transfer outside load")
  `FBF_ASSERT_IMPL(a_load_free, clk, rst, out_load |-> out_free || !out_valid, "output overrun")
  `FBF_ASSERT_NEVER(a_in_emit, clk, rst, in_take && cmd.emit, "input during emit")
endmodule
`default_nettype wire

### verif/tb_fft_bandpass_frame_filter_core.sv
`timescale 1ns / 1ps
module tb_fft_bandpass_frame_filter_core;
  import fbf_pkg::*;

  localparam int N = 64;
  localparam int HALF = N / 2;
  // indexes past the two real registers, the block must ignore them
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  typedef enum logic { ROW_DATA, ROW_CFG } row_kind_t;

  // one row of the directed table
  typedef struct {
    row_kind_t        kind;
    logic [1:0]       idx;
    logic [7:0]       data;
    logic signed [15:0] smp;
    bit               last;
    bit               zero_frame;  // frame closed here must come out all zero
  } row_t;

  typedef struct {
    logic signed [15:0] smp;
    bit                 last;
    bit                 zero_frame;
  } in_item_t;

  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } out_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] sample = '0;
  logic last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] filtered_sample;
  logic last_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  fft_bandpass_frame_filter_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last_in(last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .filtered_sample(filtered_sample), .last_out(last_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor copy of the band registers
  logic [7:0] band_start = 8'd0;
  logic [7:0] band_stop = 8'd64;

  in_item_t  send_q[$];
  out_item_t pending_outputs[$];
  logic signed [15:0] frame_samples[$];
  bit frame_zero_flag;

  longint tw_cos[0:N-1];
  longint tw_sin[0:N-1];
  longint fre[0:N-1];
  longint fim[0:N-1];

  int errors = 0;
  int frames_closed = 0;
  int outputs_checked = 0;
  int items_sent = 0;

  // sin((pi/2)*num/den) in Q1.15, ten-term series in Q2.30
  function automatic longint quarter_sine(longint num, longint den);
    longint x, term, sum;
    x = 64'sd1686629713 * num / den;
    term = x;
    sum = x;
    for (int n = 1; n <= 9; n++) begin
      term = (term * x) >>> 30;
      term = ((term * x) >>> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum -= term;
      else sum += term;
    end
    if (sum < 0) sum = 0;
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) sum = 32767;
    return sum;
  endfunction

  function automatic void build_twiddles();
    longint cr, sr;
    int q4, quad, r;
    q4 = N / 4;
    for (int k = 0; k < N; k++) begin
      quad = (k / q4) % 4;
      r = k % q4;
      cr = quarter_sine(q4 - r, q4);
      sr = quarter_sine(r, q4);
      case (quad)
        0: begin tw_cos[k] = cr; tw_sin[k] = sr; end
        1: begin tw_cos[k] = -sr; tw_sin[k] = cr; end
        2: begin tw_cos[k] = -cr; tw_sin[k] = -sr; end
        default: begin tw_cos[k] = sr; tw_sin[k] = -cr; end
      endcase
    end
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // floor((v + half) / 2^s)
  function automatic longint round_up(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int spectrum_bin(logic [7:0] f);
    int b;
    b = (int'(f) * N) >> 7;
    return (b > HALF + 1) ? HALF + 1 : b;
  endfunction

  // in-place radix-2, forward halves each stage, inverse saturates only
  function automatic void transform(bit inv);
    int r, half_len, step;
    longint wr, wi, tr, ti, ar, ai, br, bi, t;
    for (int i = 0; i < N; i++) begin
      r = 0;
      for (int b = 0; b < 6; b++) if (i[b]) r |= 1 << (5 - b);
      if (r > i) begin
        t = fre[i]; fre[i] = fre[r]; fre[r] = t;
        t = fim[i]; fim[i] = fim[r]; fim[r] = t;
      end
    end
    for (int len = 2; len <= N; len <<= 1) begin
      half_len = len / 2;
      step = N / len;
      for (int i = 0; i < N; i += len) begin
        for (int j = 0; j < half_len; j++) begin
          wr = tw_cos[j * step];
          wi = inv ? tw_sin[j * step] : -tw_sin[j * step];
          ar = fre[i + j]; ai = fim[i + j];
          br = fre[i + j + half_len]; bi = fim[i + j + half_len];
          tr = round_up(br * wr - bi * wi, 15);
          ti = round_up(br * wi + bi * wr, 15);
          if (inv) begin
            fre[i + j] = clip(ar + tr, 24); fim[i + j] = clip(ai + ti, 24);
            fre[i + j + half_len] = clip(ar - tr, 24);
            fim[i + j + half_len] = clip(ai - ti, 24);
          end else begin
            fre[i + j] = clip((ar + tr + 1) >>> 1, 24);
            fim[i + j] = clip((ai + ti + 1) >>> 1, 24);
            fre[i + j + half_len] = clip((ar - tr + 1) >>> 1, 24);
            fim[i + j + half_len] = clip((ai - ti + 1) >>> 1, 24);
          end
        end
      end
    end
  endfunction

  // band-limit the collected frame and queue its N filtered samples
  function automatic void filter_frame(bit typed_zero);
    int lo, hi;
    out_item_t o;
    for (int k = 0; k < N; k++) begin
      fre[k] = (k < frame_samples.size()) ? longint'(frame_samples[k]) * 256 : 0;
      fim[k] = 0;
    end
    transform(1'b0);
    lo = spectrum_bin(band_start);
    hi = spectrum_bin(band_stop);
    for (int k = 0; k <= HALF; k++)
      if (k < lo || k >= hi) begin fre[k] = 0; fim[k] = 0; end
    // dc and nyquist carry no imaginary part
    fim[0] = 0;
    fim[HALF] = 0;
    for (int k = HALF + 1; k < N; k++) begin
      fre[k] = fre[N - k];
      fim[k] = clip(-fim[N - k], 24);
    end
    transform(1'b1);
    for (int k = 0; k < N; k++) begin
      o.value = typed_zero ? 16'sd0 : 16'(clip(round_up(fre[k], 8), 16));
      o.last = (k == N - 1);
      pending_outputs.push_back(o);
    end
    frames_closed++;
  endfunction

  function automatic void take_sample(logic signed [15:0] s, bit last, bit zf);
    frame_samples.push_back(s);
    if (zf) frame_zero_flag = 1'b1;
    if (last || frame_samples.size() == N) begin
      filter_frame(frame_zero_flag);
      frame_samples.delete();
      frame_zero_flag = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at output %0d: %s got %0d want %0d", outputs_checked, what, got, want);
    errors++;
  endtask

  // gap lengths: mostly none or short, now and then long, with calm stretches
  bit calm = 1'b0;
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 99) == 0) calm = ~calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input side: hold payload until transfer, then gap, then next item
  int in_gap = 0;
  bit in_take;
  in_item_t in_cur, in_next;
  always @(posedge clk) begin
    if (!rst) begin
      in_take = in_valid && !in_stall;
      if (in_take) take_sample(sample, last_in, in_cur.zero_frame);
      if (in_valid && !in_take) begin
        // stalled, keep everything
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (send_q.size() > 0) begin
        in_next = send_q.pop_front();
        in_cur = in_next;
        sample <= in_next.smp;
        last_in <= in_next.last;
        in_valid <= 1'b1;
        in_gap = pick_gap();
        items_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: check each transfer, stall at random
  int out_hold = 0;
  out_item_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_outputs.size() == 0) begin
          report_mismatch("unexpected output, value", filtered_sample, 0);
        end else begin
          want = pending_outputs.pop_front();
          if (filtered_sample !== want.value)
            report_mismatch("filtered_sample", filtered_sample, want.value);
          if (last_out !== want.last)
            report_mismatch("last_out", last_out, want.last);
        end
        outputs_checked++;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_hold = pick_gap();
      end
    end
  end

  // settle: nothing queued, nothing owed, then let the block go quiet
  task automatic wait_idle();
    do @(posedge clk);
    while (send_q.size() != 0 || in_valid || pending_outputs.size() != 0
           || frame_samples.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_START) band_start = data;
    else if (idx == CFG_STOP) band_stop = data;
  endtask

  task automatic push_item(logic signed [15:0] s, bit last, bit zf);
    in_item_t it;
    it.smp = s;
    it.last = last;
    it.zero_frame = zf;
    send_q.push_back(it);
  endtask

  // one frame of random content, sometimes cut short or split by a stray last
  task automatic random_frame();
    int len, r;
    bit last;
    r = $urandom_range(0, 99);
    if (r < 50) len = $urandom_range(1, 8);
    else if (r < 85) len = $urandom_range(9, 63);
    else len = N;
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) last = (len == N) ? bit'($urandom_range(0, 1)) : 1'b1;
      else last = ($urandom_range(0, 39) == 0);
      push_item(16'($urandom), last, 1'b0);
    end
  endtask

  row_t table_rows[$];
  function automatic row_t data_row(logic signed [15:0] s, bit last, bit zf);
    row_t r;
    r.kind = ROW_DATA; r.idx = '0; r.data = '0;
    r.smp = s; r.last = last; r.zero_frame = zf;
    return r;
  endfunction
  function automatic row_t cfg_row(logic [1:0] idx, logic [7:0] data);
    row_t r;
    r.kind = ROW_CFG; r.idx = idx; r.data = data;
    r.smp = '0; r.last = 1'b0; r.zero_frame = 1'b0;
    return r;
  endfunction

  initial begin
    int pick;
    logic [7:0] a, b;
    build_twiddles();
    frame_zero_flag = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset band, extremes, short frames, clamp, empty/inverted/dc bands, spare regs
    table_rows.push_back(data_row(16'sd0, 1'b1, 1'b1));          // zero frame
    table_rows.push_back(data_row(16'sd32767, 1'b1, 1'b0));
    table_rows.push_back(data_row(-16'sd32768, 1'b1, 1'b0));
    table_rows.push_back(data_row(16'sd16384, 1'b0, 1'b0));      // short frame
    table_rows.push_back(data_row(-16'sd100, 1'b0, 1'b0));
    table_rows.push_back(data_row(16'sd7, 1'b1, 1'b0));
    table_rows.push_back(cfg_row(CFG_START, 8'd0));              // stop clamps past nyquist
    table_rows.push_back(cfg_row(CFG_STOP, 8'd255));
    table_rows.push_back(data_row(-16'sd32768, 1'b1, 1'b0));
    table_rows.push_back(cfg_row(CFG_START, 8'd255));            // empty band
    table_rows.push_back(cfg_row(CFG_STOP, 8'd255));
    table_rows.push_back(data_row(16'sd32767, 1'b1, 1'b1));
    table_rows.push_back(cfg_row(CFG_START, 8'd100));            // inverted band
    table_rows.push_back(cfg_row(CFG_STOP, 8'd20));
    table_rows.push_back(data_row(-16'sd32768, 1'b1, 1'b1));
    table_rows.push_back(cfg_row(REG_SPARE_A, 8'hAA));           // ignored indexes
    table_rows.push_back(cfg_row(REG_SPARE_B, 8'h55));
    table_rows.push_back(cfg_row(CFG_START, 8'd0));              // stop bin zero keeps nothing
    table_rows.push_back(cfg_row(CFG_STOP, 8'd1));
    table_rows.push_back(data_row(16'sd12345, 1'b1, 1'b1));
    table_rows.push_back(cfg_row(CFG_STOP, 8'd2));               // dc only
    table_rows.push_back(data_row(16'sd32767, 1'b1, 1'b0));
    table_rows.push_back(data_row(-16'sd1, 1'b1, 1'b0));

    foreach (table_rows[i]) begin
      if (table_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(table_rows[i].idx, table_rows[i].data);
      end else begin
        push_item(table_rows[i].smp, table_rows[i].last, table_rows[i].zero_frame);
      end
    end

    // random phases: new band, then a few frames
    while (items_sent + send_q.size() < 165) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      if (pick == 0) begin a = 8'd0; b = 8'd255; end
      else if (pick == 1) begin a = 8'd255; b = 8'd0; end
      else begin a = 8'($urandom); b = 8'($urandom); end
      write_reg(CFG_START, a);
      write_reg(CFG_STOP, b);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 8'($urandom));
      repeat ($urandom_range(2, 4)) random_frame();
    end
    // a full frame may end without last, close whatever is left open
    push_item(16'($urandom), 1'b1, 1'b0);
    wait_idle();

    $display("checked %0d outputs over %0d frames from %0d input samples",
             outputs_checked, frames_closed, items_sent);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout with %0d outputs still owed", pending_outputs.size());
    $display("FAILED: results differ");
    $finish;
  end
endmodule
